// File: hw/rtl/hrg_pkg.sv
// Shared constants, types and the CORDIC arctangent table for the haversine recenter gate.
package hrg_pkg;

  // Fixed-point configuration
  localparam int FRAC_BITS    = 28;
  localparam int CORDIC_ITERS = 32;
  localparam int WB           = 30;
  localparam int ITER_W       = $clog2(CORDIC_ITERS);

  // Datapath widths
  localparam int AW     = 36;             // CORDIC and angle registers
  localparam int MW     = 34;             // multiplier operand
  localparam int PW     = 2 * MW;         // multiplier product
  localparam int SW     = 2 * WB + 2;     // square-root radicand
  localparam int RW     = WB + 1;         // square root
  localparam int LGP_W  = $clog2(WB + 2); // integer part of log2
  localparam int LG_W   = LGP_W + WB;     // log2 value
  localparam int LAT_W  = 31;
  localparam int LON_W  = 32;
  localparam int DIST_W = 25;
  localparam int MX_W   = 31;
  localparam int MY_W   = 32;

  // Constants at scale 2^-30 unless noted
  localparam logic signed [MW-1:0] DEG_RAD   = 34'sd2012227627; // rad per 1e-7 deg, 2^-60
  localparam logic signed [AW-1:0] ONE_W     = 36'sd1073741824;
  localparam logic signed [AW-1:0] PI_W      = 36'sd3373259426;
  localparam logic signed [AW-1:0] TWO_PI_W  = 36'sd6746518852;
  localparam logic signed [AW-1:0] HALF_PI_W = 36'sd1686629713;
  localparam logic signed [AW-1:0] GAIN_W    = 36'sd652032874;
  localparam logic signed [MW-1:0] LN2_W     = 34'sd744261118;
  localparam logic signed [MW-1:0] TWO_R_M   = 34'sd12742000;   // sphere diameter, meters
  localparam logic signed [MY_W-1:0] MERC_Y_LIM = 32'sd1073741824;
  localparam logic [DIST_W-1:0] MIN_DIST_RESET = 25'd10000;

  // CORDIC unit command
  typedef struct packed {
    logic start;
    logic vector;   // 1: vectoring, 0: rotation
  } cordic_cmd_t;

  // atan(2^-i) at scale 2^-30
  function automatic logic signed [AW-1:0] atan_w(input logic [ITER_W-1:0] i);
    logic signed [AW-1:0] r;
    unique case (i)
      ITER_W'(0):  r = 36'sd843314857;
      ITER_W'(1):  r = 36'sd497837829;
      ITER_W'(2):  r = 36'sd263043837;
      ITER_W'(3):  r = 36'sd133525159;
      ITER_W'(4):  r = 36'sd67021687;
      ITER_W'(5):  r = 36'sd33543516;
      ITER_W'(6):  r = 36'sd16775851;
      ITER_W'(7):  r = 36'sd8388437;
      ITER_W'(8):  r = 36'sd4194283;
      ITER_W'(9):  r = 36'sd2097149;
      ITER_W'(10): r = 36'sd1048576;
      default:     r = (int'(i) <= WB) ? $signed(AW'(1) << (WB - int'(i))) : '0;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/hrg_cordic.sv
// Shared CORDIC unit, rotation or vectoring, one micro-rotation per cycle.
module hrg_cordic (
  input  logic                           clk,
  input  logic                           rst,
  input  hrg_pkg::cordic_cmd_t           cmd,
  input  logic signed [hrg_pkg::AW-1:0]  x0,
  input  logic signed [hrg_pkg::AW-1:0]  y0,
  input  logic signed [hrg_pkg::AW-1:0]  z0,
  output logic                           done,
  output logic signed [hrg_pkg::AW-1:0]  x,
  output logic signed [hrg_pkg::AW-1:0]  y,
  output logic signed [hrg_pkg::AW-1:0]  z
);
  import hrg_pkg::*;

  logic              busy;
  logic              vec;
  logic [ITER_W-1:0] i;
  logic              plus;
  logic signed [AW-1:0] dx, dy, da;

  // step direction: rotate toward z = 0 or toward y = 0
  always_comb begin
    dx   = y >>> i;
    dy   = x >>> i;
    da   = atan_w(i);
    plus = vec ? y[AW-1] : !z[AW-1];
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
      end else if (busy && i == ITER_W'(CORDIC_ITERS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x   <= x0;
      y   <= y0;
      z   <= z0;
      vec <= cmd.vector;
      i   <= '0;
    end else if (busy) begin
      if (plus) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - da;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + da;
      end
      i <= i + 1'b1;
    end
  end

endmodule

// File: hw/rtl/hrg_sqrt.sv
// Bit-serial floor square root, two radicand bits per cycle.
module hrg_sqrt (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [hrg_pkg::SW-1:0]  v,
  output logic                    done,
  output logic [hrg_pkg::RW-1:0]  root
);
  import hrg_pkg::*;

  logic          busy;
  logic [SW-1:0] rem, r, bitm, trial;
  logic          ge;

  always_comb begin
    trial = r + bitm;
    ge    = rem >= trial;
    root  = r[RW-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bitm[0]) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // restoring root step
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= v;
      r    <= '0;
      bitm <= SW'(1) << (SW - 2);
    end else if (busy) begin
      if (ge) begin
        rem <= rem - trial;
        r   <= (r >> 1) + bitm;
      end else begin
        r   <= r >> 1;
      end
      bitm <= bitm >> 2;
    end
  end

endmodule

// File: hw/rtl/hrg_log2.sv
// Fixed-point log2: normalize one bit a cycle, then one fraction bit per squaring.
module hrg_log2 (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [hrg_pkg::WB+1:0]    v,
  output logic                      done,
  output logic [hrg_pkg::LG_W-1:0]  lg
);
  import hrg_pkg::*;

  typedef enum logic [2:0] {
    L_IDLE = 3'b001,
    L_NORM = 3'b010,
    L_SQR  = 3'b100
  } phase_t;

  localparam int KW = $clog2(WB);

  phase_t               phase;
  logic [WB+1:0]        u;
  logic [LGP_W-1:0]     p;
  logic [WB-1:0]        frac;
  logic [KW-1:0]        k;
  logic [2*WB+3:0]      sq;
  logic [WB+1:0]        sqs;

  always_comb begin
    sq  = u * u;
    sqs = sq[WB +: WB + 2];
    lg  = {p, frac};
  end

  // phase control
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= L_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        L_IDLE: begin
          if (start) phase <= L_NORM;
        end
        L_NORM: begin
          if (u[WB]) phase <= L_SQR;
        end
        L_SQR: begin
          if (k == KW'(WB - 1)) begin
            phase <= L_IDLE;
            done  <= 1'b1;
          end
        end
        default: phase <= L_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      if (v[WB+1]) begin
        u <= v >> 1;
        p <= LGP_W'(WB + 1);
      end else begin
        u <= v;
        p <= LGP_W'(WB);
      end
      k <= '0;
    end else if (phase == L_NORM) begin
      if (!u[WB]) begin
        u <= u << 1;
        p <= p - 1'b1;
      end
    end else if (phase == L_SQR) begin
      if (sqs[WB+1]) begin
        u    <= sqs >> 1;
        frac <= {frac[WB-2:0], 1'b1};
      end else begin
        u    <= sqs;
        frac <= {frac[WB-2:0], 1'b0};
      end
      k <= k + 1'b1;
    end
  end

endmodule

// File: hw/rtl/haversine_recenter_gate_top.sv
// Top level: sequencer, shared multiplier and state of the haversine recenter gate.
//
// Each fix is one transaction in and one transaction out; the block takes one fix at a
// time and holds in_stall high while it works. A compared fix runs through a single CORDIC
// unit four times (multiply, wrap, fold, 32 micro-rotations each), two 31-step square
// roots and one 32-step vectoring pass, then the distance multiply; the first fix after
// reset runs the CORDIC unit once. A recentering fix adds the Mercator path with two
// log2 runs.
// The result waits in an output register, so a stalled consumer holds only the last
// step. The threshold written on wr_en/wr_data is compared as distance_m > threshold.
module haversine_recenter_gate_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [hrg_pkg::LAT_W-1:0]    latitude,
  input  logic signed [hrg_pkg::LON_W-1:0]    longitude,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                recenter,
  output logic [hrg_pkg::DIST_W-1:0]          distance_m,
  output logic signed [hrg_pkg::MX_W-1:0]     merc_x,
  output logic signed [hrg_pkg::MY_W-1:0]     merc_y,
  input  logic                                wr_en,
  input  logic [hrg_pkg::DIST_W-1:0]          wr_data
);
  import hrg_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_MUL   = 16'h0002,
    S_TAKE  = 16'h0004,
    S_WRAP  = 16'h0008,
    S_FOLD  = 16'h0010,
    S_CORD  = 16'h0020,
    S_CLAMP = 16'h0040,
    S_SQ1   = 16'h0080,
    S_SQ2   = 16'h0100,
    S_VEC   = 16'h0200,
    S_DEC   = 16'h0400,
    S_MERC  = 16'h0800,
    S_LN1   = 16'h1000,
    S_LN2   = 16'h2000,
    S_MY    = 16'h4000,
    S_OUT   = 16'h8000
  } state_t;

  typedef enum logic [3:0] {
    OP_ANG, OP_H1, OP_H2, OP_H3, OP_H4, OP_DIST, OP_MX, OP_LNH, OP_LNL
  } op_t;

  typedef enum logic [1:0] {
    ANG_LAT, ANG_LAST, ANG_DLAT, ANG_DLON
  } ang_t;

  localparam int TW   = 36;
  localparam int SH_A = 60 - WB;
  localparam int SH_D = 61 - WB;
  localparam int SH_X = 60 - FRAC_BITS;
  localparam int SH_Y = WB + 1 - FRAC_BITS;
  localparam logic signed [PW-1:0] RND_W = PW'(1) << (WB - 1);
  localparam logic signed [PW-1:0] RND_A = PW'(1) << (SH_A - 1);
  localparam logic signed [PW-1:0] RND_D = PW'(1) << (SH_D - 1);
  localparam logic signed [PW-1:0] RND_X = PW'(1) << (SH_X - 1);
  localparam logic [TW-1:0]        RND_Y = TW'(1) << (WB - FRAC_BITS);
  localparam logic signed [PW-1:0] MX_HI = PW'((64'd1 << (MX_W - 1)) - 64'd1);
  localparam logic signed [PW-1:0] MX_LO = -MX_HI - 1;

  state_t state;
  op_t    op;
  ang_t   k;

  // fix and stored state
  logic signed [LAT_W-1:0] lat, last_lat;
  logic signed [LON_W-1:0] lon, last_lon;
  logic                    have_fix;
  logic [DIST_W-1:0]       min_dist;

  // work registers
  logic signed [PW-1:0]    prod;
  logic signed [AW-1:0]    zr, acc;
  logic                    flip;
  logic signed [MW-1:0]    s2, c2, c1, sdl, sdo, hv1, hv2, hv3, zang;
  logic [RW-1:0]           ys;
  logic [DIST_W-1:0]       span;
  logic                    rec;
  logic signed [MX_W-1:0]  mx;
  logic signed [MY_W-1:0]  my;
  logic [LG_W-1:0]         ln_n, mag;
  logic                    neg;
  logic [TW-1:0]           tacc;

  // combinational
  logic signed [MW-1:0]    ma, mb;
  logic signed [LAT_W:0]   dlat;
  logic signed [LON_W:0]   dlon;
  logic signed [PW-1:0]    rnd_w, rnd_a, rnd_x, mx_full;
  logic signed [AW-1:0]    z_f, a_c, n_v, m_v, c_s, c_c;
  logic signed [LG_W:0]    ld;
  logic                    flip_f, rec_n, accept, out_load;
  logic [TW-1:0]           t_r, t_s;

  // unit ports
  cordic_cmd_t             ccmd;
  logic signed [AW-1:0]    cx0, cy0, cz0, cx, cy, cz;
  logic                    c_done;
  logic                    sq_start, sq_done;
  logic [SW-1:0]           sq_v;
  logic [RW-1:0]           sq_root;
  logic                    lg_start, lg_done;
  logic [WB+1:0]           lg_v;
  logic [LG_W-1:0]         lg;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  // shared multiplier operand select
  always_comb begin
    dlat = {lat[LAT_W-1], lat} - {last_lat[LAT_W-1], last_lat};
    dlon = {lon[LON_W-1], lon} - {last_lon[LON_W-1], last_lon};
    ma   = '0;
    mb   = '0;
    unique case (op)
      OP_ANG: begin
        mb = DEG_RAD;
        unique case (k)
          ANG_LAT:  ma = MW'(lat);
          ANG_LAST: ma = MW'(last_lat);
          ANG_DLAT: ma = MW'(dlat);
          ANG_DLON: ma = MW'(dlon);
          default:  ma = '0;
        endcase
      end
      OP_H1:   begin ma = sdl;  mb = sdl;     end
      OP_H2:   begin ma = c1;   mb = c2;      end
      OP_H3:   begin ma = sdo;  mb = sdo;     end
      OP_H4:   begin ma = hv2;  mb = hv3;     end
      OP_DIST: begin ma = zang; mb = TWO_R_M; end
      OP_MX:   begin ma = MW'(lon); mb = DEG_RAD; end
      OP_LNH:  begin ma = $signed(MW'(mag[LG_W-1:WB])); mb = LN2_W; end
      OP_LNL:  begin ma = $signed(MW'(mag[WB-1:0]));    mb = LN2_W; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // rounding, folding, clamping and Mercator helpers
  always_comb begin
    rnd_w   = (prod + RND_W) >>> WB;
    rnd_a   = (k == ANG_LAT || k == ANG_LAST) ? ((prod + RND_A) >>> SH_A)
                                              : ((prod + RND_D) >>> SH_D);
    rnd_x   = (prod + RND_X) >>> SH_X;
    mx_full = (rnd_x > MX_HI) ? MX_HI : ((rnd_x < MX_LO) ? MX_LO : rnd_x);

    z_f    = zr;
    flip_f = 1'b0;
    if (zr > HALF_PI_W) begin
      z_f    = zr - PI_W;
      flip_f = 1'b1;
    end else if (zr < -HALF_PI_W) begin
      z_f    = zr + PI_W;
      flip_f = 1'b1;
    end

    c_s = flip ? -cy : cy;
    c_c = flip ? -cx : cx;

    a_c = acc[AW-1] ? '0 : ((acc > ONE_W) ? ONE_W : acc);

    n_v = ONE_W + AW'(s2);
    m_v = ONE_W - AW'(s2);
    ld  = $signed({1'b0, ln_n}) - $signed({1'b0, lg});

    t_r = (tacc + RND_Y) >> SH_Y;
    t_s = (t_r > TW'(MERC_Y_LIM)) ? TW'(MERC_Y_LIM) : t_r;

    rec_n = !have_fix || (span > min_dist);
  end

  // unit starts and operands
  always_comb begin
    ccmd.start  = (state == S_FOLD) || (state == S_SQ2 && sq_done);
    ccmd.vector = (state == S_SQ2);
    cx0 = (state == S_SQ2) ? $signed(AW'(sq_root)) : GAIN_W;
    cy0 = (state == S_SQ2) ? $signed(AW'(ys)) : '0;
    cz0 = (state == S_SQ2) ? '0 : z_f;

    sq_start = (state == S_CLAMP) || (state == S_SQ1 && sq_done);
    sq_v     = (state == S_CLAMP) ? (SW'(a_c[WB:0]) << WB)
                                  : (SW'(ONE_W[WB:0] - acc[WB:0]) << WB);

    lg_start = (state == S_MERC && !m_v[AW-1] && m_v != '0 && !n_v[AW-1] && n_v != '0)
            || (state == S_LN1 && lg_done);
    lg_v     = (state == S_MERC) ? n_v[WB+1:0] : m_v[WB+1:0];
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_dist <= MIN_DIST_RESET;
    end else if (wr_en) begin
      min_dist <= wr_data;
    end
  end

  // multiplier product register
  always_ff @(posedge clk) begin
    if (state == S_MUL) prod <= ma * mb;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      op       <= OP_ANG;
      k        <= ANG_LAT;
      have_fix <= 1'b0;
      last_lat <= '0;
      last_lon <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            lat   <= latitude;
            lon   <= longitude;
            span  <= '0;
            k     <= ANG_LAT;
            op    <= OP_ANG;
            state <= S_MUL;
          end
        end
        S_MUL: state <= S_TAKE;
        S_TAKE: begin
          unique case (op)
            OP_ANG: begin
              zr    <= rnd_a[AW-1:0];
              state <= S_WRAP;
            end
            OP_H1: begin hv1 <= rnd_w[MW-1:0]; op <= OP_H2; state <= S_MUL; end
            OP_H2: begin hv2 <= rnd_w[MW-1:0]; op <= OP_H3; state <= S_MUL; end
            OP_H3: begin hv3 <= rnd_w[MW-1:0]; op <= OP_H4; state <= S_MUL; end
            OP_H4: begin
              acc   <= AW'(hv1) + rnd_w[AW-1:0];
              state <= S_CLAMP;
            end
            OP_DIST: begin
              span  <= rnd_w[DIST_W-1:0];
              state <= S_DEC;
            end
            OP_MX: begin
              mx    <= mx_full[MX_W-1:0];
              state <= S_MERC;
            end
            OP_LNH: begin
              tacc  <= prod[TW-1:0];
              op    <= OP_LNL;
              state <= S_MUL;
            end
            OP_LNL: begin
              tacc  <= tacc + rnd_w[TW-1:0] - ((prod + RND_W) >>> WB != prod >>> WB ?
                       TW'(((prod + RND_W) >>> WB) - (prod >>> WB)) : '0);
              state <= S_MY;
            end
            default: state <= S_IDLE;
          endcase
        end
        // single wrap into [-pi, pi]
        S_WRAP: begin
          if (zr > PI_W) zr <= zr - TWO_PI_W;
          else if (zr < -PI_W) zr <= zr + TWO_PI_W;
          state <= S_FOLD;
        end
        S_FOLD: begin
          flip  <= flip_f;
          state <= S_CORD;
        end
        S_CORD: begin
          if (c_done) begin
            unique case (k)
              ANG_LAT:  begin s2 <= c_s[MW-1:0]; c2 <= c_c[MW-1:0]; end
              ANG_LAST: c1  <= c_c[MW-1:0];
              ANG_DLAT: sdl <= c_s[MW-1:0];
              ANG_DLON: sdo <= c_s[MW-1:0];
              default:  ;
            endcase
            if (k == ANG_LAT && !have_fix) begin
              state <= S_DEC;
            end else if (k == ANG_DLON) begin
              op    <= OP_H1;
              state <= S_MUL;
            end else begin
              k     <= ang_t'(k + 2'd1);
              op    <= OP_ANG;
              state <= S_MUL;
            end
          end
        end
        S_CLAMP: begin
          acc   <= a_c;
          state <= S_SQ1;
        end
        S_SQ1: begin
          if (sq_done) begin
            ys    <= sq_root;
            state <= S_SQ2;
          end
        end
        S_SQ2: begin
          if (sq_done) state <= S_VEC;
        end
        S_VEC: begin
          if (c_done) begin
            zang  <= cz[AW-1] ? '0 : cz[MW-1:0];
            op    <= OP_DIST;
            state <= S_MUL;
          end
        end
        // recenter decision
        S_DEC: begin
          rec <= rec_n;
          if (rec_n) begin
            last_lat <= lat;
            last_lon <= lon;
            have_fix <= 1'b1;
            op       <= OP_MX;
            state    <= S_MUL;
          end else begin
            mx    <= '0;
            my    <= '0;
            state <= S_OUT;
          end
        end
        S_MERC: begin
          if (m_v[AW-1] || m_v == '0) begin
            my    <= MERC_Y_LIM;
            state <= S_OUT;
          end else if (n_v[AW-1] || n_v == '0) begin
            my    <= -MERC_Y_LIM;
            state <= S_OUT;
          end else begin
            state <= S_LN1;
          end
        end
        S_LN1: begin
          if (lg_done) begin
            ln_n  <= lg;
            state <= S_LN2;
          end
        end
        S_LN2: begin
          if (lg_done) begin
            neg   <= ld[LG_W];
            mag   <= ld[LG_W] ? LG_W'(-ld) : ld[LG_W-1:0];
            op    <= OP_LNH;
            state <= S_MUL;
          end
        end
        S_MY: begin
          my    <= neg ? -MY_W'(t_s) : MY_W'(t_s);
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      recenter   <= rec;
      distance_m <= span;
      merc_x     <= mx;
      merc_y     <= my;
    end
  end

  hrg_cordic u_cordic (
    .clk  (clk),
    .rst  (rst),
    .cmd  (ccmd),
    .x0   (cx0),
    .y0   (cy0),
    .z0   (cz0),
    .done (c_done),
    .x    (cx),
    .y    (cy),
    .z    (cz)
  );

  hrg_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .v     (sq_v),
    .done  (sq_done),
    .root  (sq_root)
  );

  hrg_log2 u_log2 (
    .clk   (clk),
    .rst   (rst),
    .start (lg_start),
    .v     (lg_v),
    .done  (lg_done),
    .lg    (lg)
  );

`ifndef SYNTHESIS
  a_load_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result register loaded outside the output step");
  a_skip_clears_merc: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !recenter) |-> (merc_x == '0 && merc_y == '0))
    else $error("rejected fix carries Mercator coordinates");
  a_fix_stored: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> have_fix)
    else $error("result delivered with no stored fix");
  a_merc_y_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(merc_y) <= MERC_Y_LIM && $signed(merc_y) >= -MERC_Y_LIM))
    else $error("merc_y beyond saturation limit");
`endif

endmodule

// File: verif/tb.sv
// Testbench for the haversine recenter gate: bursty driver, stalling receiver, monitor, fixed-point predictor.
module tb;
  import hrg_pkg::*;

  typedef struct {
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
  } fix_t;

  typedef struct {
    logic                     recenter;
    logic [DIST_W-1:0]        span;
    logic signed [MX_W-1:0]   mx;
    logic signed [MY_W-1:0]   my;
  } gate_out_t;

  localparam longint W_ONE   = 64'sd1073741824;
  localparam longint W_PI    = 64'sd3373259426;
  localparam longint W_HPI   = 64'sd1686629713;
  localparam longint W_GAIN  = 64'sd652032874;
  localparam longint DEG2RAD = 64'sd2012227627;
  localparam longint DIAM_M  = 64'sd12742000;
  localparam longint Y_SAT   = 64'sd1073741824;
  localparam longint X_HI    = 64'sd1073741823;
  localparam longint X_LO    = -64'sd1073741824;
  localparam int     NSTEP   = 32;
  localparam longint TIMEOUT = 64'd4000000;
  localparam logic [DIST_W-1:0] THRESH_MAX = '1;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic signed [LAT_W-1:0] latitude = '0;
  logic signed [LON_W-1:0] longitude = '0;
  logic out_valid;
  logic out_stall = 0;
  logic recenter;
  logic [DIST_W-1:0] distance_m;
  logic signed [MX_W-1:0] merc_x;
  logic signed [MY_W-1:0] merc_y;
  logic wr_en = 0;
  logic [DIST_W-1:0] wr_data = '0;

  haversine_recenter_gate_top dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // predictor state
  longint anchor_lat = 0, anchor_lon = 0;
  bit anchored = 0;
  longint threshold_m = 10000;

  fix_t pending_fixes[$];
  gate_out_t expected_outs[$];
  int errors = 0;
  int accepted_fixes = 0;
  longint cycles = 0;

  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint mul_w(longint a, longint b);
    return round_shift(a * b, 30);
  endfunction

  function automatic longint arctan_step(int i);
    longint tab[11] = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                        16775851, 8388437, 4194283, 2097149, 1048576};
    if (i <= 10) return tab[i];
    if (i <= 30) return 64'sd1 <<< (30 - i);
    return 0;
  endfunction

  // rotation CORDIC with range reduction and fold to the right half plane
  task automatic sin_cos(input longint ang, output longint s, output longint c);
    longint x, y, z, dx, dy;
    bit flip;
    x = W_GAIN; y = 0; z = ang; flip = 0;
    while (z > W_PI) z -= 2 * W_PI;
    while (z < -W_PI) z += 2 * W_PI;
    if (z > W_HPI) begin
      z -= W_PI; flip = 1;
    end else if (z < -W_HPI) begin
      z += W_PI; flip = 1;
    end
    for (int i = 0; i < NSTEP; i++) begin
      dx = y >>> i; dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_step(i);
      end else begin
        x += dx; y -= dy; z += arctan_step(i);
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endtask

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0; b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint vector_angle(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < NSTEP; i++) begin
      dx = y >>> i; dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += arctan_step(i);
      end else begin
        x -= dx; y += dy; z -= arctan_step(i);
      end
    end
    return z;
  endfunction

  function automatic longint log2_fx(longint unsigned v);
    int p;
    longint unsigned u;
    longint frac;
    p = 0; frac = 0;
    while ((v >> (p + 1)) != 0) p++;
    u = (p >= 30) ? (v >> (p - 30)) : (v << (30 - p));
    for (int k = 0; k < 30; k++) begin
      u = (u * u) >> 30;
      if (u >= (64'd1 << 31)) begin
        u >>= 1; frac |= 64'sd1 <<< (29 - k);
      end
    end
    return longint'(p) * W_ONE + frac;
  endfunction

  function automatic longint northing(longint s);
    longint n, m, ld, y;
    longint unsigned mag, t;
    n = W_ONE + s; m = W_ONE - s;
    if (m <= 0) return Y_SAT;
    if (n <= 0) return -Y_SAT;
    ld = log2_fx(n) - log2_fx(m);
    mag = (ld < 0) ? -ld : ld;
    t = (mag >> 30) * 64'd744261118 + (((mag & ((64'd1 << 30) - 1)) * 64'd744261118) >> 30);
    t = (t + (64'd1 << (30 - FRAC_BITS))) >> (31 - FRAC_BITS);
    y = (t > Y_SAT) ? Y_SAT : longint'(t);
    return (ld < 0) ? -y : y;
  endfunction

  // distance gate on one fix; updates the stored anchor when it recenters
  task automatic gate_fix(input fix_t f, output gate_out_t r);
    longint lat, lon, s2, c2, s1, c1, sdl, cdl, sdo, cdo, a, z, mx, my;
    longint unsigned ys, xs, span;
    bit rec;
    lat = f.lat; lon = f.lon; mx = 0; my = 0; span = 0;
    sin_cos(round_shift(lat * DEG2RAD, 30), s2, c2);
    if (anchored) begin
      sin_cos(round_shift(anchor_lat * DEG2RAD, 30), s1, c1);
      sin_cos(round_shift((lat - anchor_lat) * DEG2RAD, 31), sdl, cdl);
      sin_cos(round_shift((lon - anchor_lon) * DEG2RAD, 31), sdo, cdo);
      a = mul_w(sdl, sdl) + mul_w(mul_w(c1, c2), mul_w(sdo, sdo));
      if (a < 0) a = 0;
      if (a > W_ONE) a = W_ONE;
      ys = floor_sqrt(longint'(a) << 30);
      xs = floor_sqrt(longint'(W_ONE - a) << 30);
      z = vector_angle(xs, ys);
      if (z < 0) z = 0;
      span = (z * DIAM_M + (64'd1 << 29)) >> 30;
    end
    rec = !anchored || span > threshold_m;
    if (rec) begin
      anchor_lat = lat; anchor_lon = lon; anchored = 1;
      mx = round_shift(lon * DEG2RAD, 60 - FRAC_BITS);
      if (mx > X_HI) mx = X_HI;
      if (mx < X_LO) mx = X_LO;
      my = northing(s2);
    end
    r.recenter = rec;
    r.span = span[DIST_W-1:0];
    r.mx = mx[MX_W-1:0];
    r.my = my[MY_W-1:0];
  endtask

  // driver: bursts of transactions separated by random gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    gate_out_t r;
    fix_t f;
    logic nv;
    if (rst) begin
      in_valid <= 0;
    end else begin
      nv = in_valid;
      if (in_valid && !in_stall) begin
        f.lat = latitude; f.lon = longitude;
        gate_fix(f, r);
        expected_outs.push_back(r);
        accepted_fixes++;
        nv = 0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_fixes.size() > 0) begin
          f = pending_fixes.pop_front();
          latitude <= f.lat;
          longitude <= f.lon;
          nv = 1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 600);
          end
        end
      end
      in_valid <= nv;
    end
  end

  // receiver stall pattern, with one long hold-off
  int run_left = 0, hold_left = 0;
  bit held = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else if (!held && accepted_fixes == 300) begin
      held = 1;
      hold_left = 3000;
      out_stall <= 1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1;
    end else if (run_left > 0) begin
      run_left--;
    end else begin
      run_left = $urandom_range(0, 200);
      out_stall <= ($urandom_range(0, 4) < 2);
    end
  end

  // monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    gate_out_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_outs.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: rec=%0d dist=%0d", recenter, distance_m);
      end else begin
        e = expected_outs.pop_front();
        if (e.recenter !== recenter || e.span !== distance_m || e.mx !== merc_x ||
            e.my !== merc_y) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp rec=%0d dist=%0d x=%0d y=%0d got rec=%0d dist=%0d x=%0d y=%0d",
                     e.recenter, e.span, e.mx, e.my, recenter, distance_m, merc_x, merc_y);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > TIMEOUT) begin
      $display("tb: errors");
      $finish;
    end
  end

  task automatic drain();
    wait (pending_fixes.size() == 0);
    while (in_valid || expected_outs.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic set_threshold(logic [DIST_W-1:0] v);
    @(posedge clk);
    wr_en <= 1;
    wr_data <= v;
    @(posedge clk);
    wr_en <= 0;
    threshold_m = v;
  endtask

  task automatic add_fix(longint lat, longint lon);
    fix_t f;
    f.lat = lat[LAT_W-1:0];
    f.lon = lon[LON_W-1:0];
    pending_fixes.push_back(f);
  endtask

  function automatic longint spread(int m);
    return longint'($urandom_range(0, 2 * m)) - m;
  endfunction

  // random walk around a base point, with occasional wild fixes
  task automatic walk(int n);
    longint lat, lon;
    int m;
    lat = spread(900000000); lon = spread(1800000000);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        add_fix(longint'($signed($urandom())), longint'($signed($urandom())));
      end else begin
        m = 10 ** $urandom_range(2, 7);
        lat += spread(m); lon += spread(m);
        if (lat > 900000000 || lat < -900000000) lat = spread(900000000);
        if (lon > 1800000000 || lon < -1800000000) lon = spread(1800000000);
        if ($urandom_range(0, 20) == 0) add_fix(lat, lon + spread(3));
        else add_fix(lat, lon);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;

    // directed: first fix, repeats, poles, antimeridian, field extremes
    add_fix(0, 0);
    add_fix(0, 0);
    add_fix(0, 1000);
    add_fix(900000000, 0);
    add_fix(-900000000, 0);
    add_fix(899999999, 1800000000);
    add_fix(0, -1800000000);
    add_fix(0, 1800000000);
    drain();
    set_threshold(0);
    add_fix(-1073741824, -64'sd2147483648);
    add_fix(1073741823, 2147483647);
    add_fix(1073741823, 2147483647);
    add_fix(0, 0);
    add_fix(0, 1);
    add_fix(-900000000, -1800000000);
    add_fix(450000000, 0);
    drain();
    set_threshold(THRESH_MAX);
    add_fix(100, 100);
    add_fix(-900000000, 1800000000);
    add_fix(900000000, -1800000000);
    drain();
    set_threshold(20015087);
    add_fix(0, 0);
    add_fix(0, 1800000000);
    drain();

    // random phases over several thresholds
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: set_threshold(10000);
        1: set_threshold($urandom_range(0, 200000));
        2: set_threshold(0);
        default: set_threshold($urandom_range(0, 2 ** DIST_W - 1));
      endcase
      walk(120);
      drain();
    end

    repeat (600) @(posedge clk);
    if (errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
